FILE: src/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants and types for the passband classifier.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Spectrum geometry
  localparam int MAX_BINS     = 1024;
  localparam int SAMPLE_WIDTH = 32;

  // Fixed field widths of the channels
  localparam int MAG_W    = 32;
  localparam int THR_W    = 32;
  localparam int KIND_W   = 3;
  localparam int OUT_IDX_W = 10;

  // Bin counter saturates at MAX_BINS, so it must hold MAX_BINS itself
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  // Edge indices never exceed MAX_BINS-2
  localparam int EDGE_W = $clog2(MAX_BINS);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BINS);
  localparam logic [MAG_W-1:0] SAMPLE_MASK = MAG_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE     = 3'd0,
    KIND_FULLPASS = 3'd1,
    KIND_LOWPASS  = 3'd2,
    KIND_HIGHPASS = 3'd3,
    KIND_BANDPASS = 3'd4,
    KIND_BANDSTOP = 3'd5
  } filter_kind_e;

  // Per-spectrum edge summary, including the bin being retired
  typedef struct packed {
    logic              all_above;
    logic              rise_found;
    logic [EDGE_W-1:0] rise_idx;
    logic              fall_found;
    logic [EDGE_W-1:0] fall_idx;
    logic              far_found;   // fall at least two bins past the rise
    logic [EDGE_W-1:0] far_idx;
  } spc_summary_t;

  // Summary at the start of a spectrum: nothing below yet, no edges
  localparam spc_summary_t SUM_CLEAR = '{
    all_above:  1'b1,
    rise_found: 1'b0,
    rise_idx:   '0,
    fall_found: 1'b0,
    fall_idx:   '0,
    far_found:  1'b0,
    far_idx:    '0
  };

  typedef struct packed {
    filter_kind_e         kind;
    logic [OUT_IDX_W-1:0] rise_bin;
    logic [OUT_IDX_W-1:0] fall_bin;
  } spc_result_t;

endpackage

FILE: src/spc_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_ifs
// Valid/ready channel interfaces: bin input, result output, threshold write.
// ----------------------------------------------------------------------------
interface spc_bin_if;
  import spc_pkg::*;
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic             final_bin;

  modport source (output valid, output magnitude, output final_bin, input ready);
  modport sink   (input valid, input magnitude, input final_bin, output ready);
endinterface

interface spc_result_if;
  import spc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [KIND_W-1:0]    filter_kind;
  logic [OUT_IDX_W-1:0] rise_bin;
  logic [OUT_IDX_W-1:0] fall_bin;

  modport source (output valid, output filter_kind, output rise_bin, output fall_bin,
                  input ready);
  modport sink   (input valid, input filter_kind, input rise_bin, input fall_bin,
                  output ready);
endinterface

interface spc_cfg_if;
  import spc_pkg::*;
  logic             valid;
  logic             ready;
  logic [THR_W-1:0] level_threshold;

  modport source (output valid, output level_threshold, input ready);
  modport sink   (input valid, input level_threshold, output ready);
endinterface

FILE: src/spc_edge_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_edge_tracker
// Threshold compare and per-spectrum edge state, one bin per step.
// ----------------------------------------------------------------------------
module spc_edge_tracker
  import spc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic             final_i,
  input  logic [THR_W-1:0] thr_i,
  output spc_summary_t     summary_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       hist_q, hist_d;
  spc_summary_t     sum_q, sum_d;

  logic              above;
  logic              edge_en;
  logic              rise_hit;
  logic              fall_hit;
  logic [EDGE_W-1:0] edge_idx;
  logic [EDGE_W:0]   rise_plus2;

  always_comb begin
    above      = (mag_i & SAMPLE_MASK) >= thr_i;
    edge_en    = (cnt_q >= CNT_W'(2)) && (cnt_q < CNT_MAX);
    edge_idx   = EDGE_W'(cnt_q - CNT_W'(1));
    rise_hit   = edge_en && !hist_q[1] && above;
    fall_hit   = edge_en && hist_q[1] && !above;
    rise_plus2 = {1'b0, sum_q.rise_idx} + (EDGE_W + 1)'(2);

    sum_d = sum_q;
    if (!above) begin
      sum_d.all_above = 1'b0;
    end
    // only the first rise counts
    if (rise_hit && !sum_q.rise_found) begin
      sum_d.rise_found = 1'b1;
      sum_d.rise_idx   = edge_idx;
    end
    if (fall_hit) begin
      if (!sum_q.fall_found) begin
        sum_d.fall_found = 1'b1;
        sum_d.fall_idx   = edge_idx;
      end
      if (sum_q.rise_found && !sum_q.far_found &&
          ({1'b0, edge_idx} >= rise_plus2)) begin
        sum_d.far_found = 1'b1;
        sum_d.far_idx   = edge_idx;
      end
    end

    hist_d = {hist_q[0], above};
    cnt_d  = (cnt_q < CNT_MAX) ? cnt_q + CNT_W'(1) : cnt_q;
  end

  assign summary_o = sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      hist_q <= '0;
      sum_q  <= SUM_CLEAR;
    end else if (step_i) begin
      if (final_i) begin
        cnt_q  <= '0;
        hist_q <= '0;
        sum_q  <= SUM_CLEAR;
      end else begin
        cnt_q  <= cnt_d;
        hist_q <= hist_d;
        sum_q  <= sum_d;
      end
    end
  end

endmodule

FILE: src/spc_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_classifier
// Maps the final edge summary of a spectrum to filter kind and bin indices.
// ----------------------------------------------------------------------------
module spc_classifier
  import spc_pkg::*;
(
  input  spc_summary_t summary_i,
  output spc_result_t  result_o
);

  always_comb begin
    result_o.kind     = KIND_NONE;
    result_o.rise_bin = '0;
    result_o.fall_bin = '0;
    if (summary_i.all_above) begin
      result_o.kind = KIND_FULLPASS;
    end else if (summary_i.rise_found) begin
      result_o.rise_bin = OUT_IDX_W'(summary_i.rise_idx);
      if (summary_i.far_found) begin
        result_o.kind     = KIND_BANDPASS;
        result_o.fall_bin = OUT_IDX_W'(summary_i.far_idx);
      end else if (summary_i.fall_found) begin
        result_o.kind     = KIND_BANDSTOP;
        result_o.fall_bin = OUT_IDX_W'(summary_i.fall_idx);
      end else begin
        result_o.kind = KIND_HIGHPASS;
      end
    end else if (summary_i.fall_found) begin
      result_o.kind     = KIND_LOWPASS;
      result_o.fall_bin = OUT_IDX_W'(summary_i.fall_idx);
    end
  end

endmodule

FILE: src/spectrum_passband_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_passband_classifier_core
// Streams magnitude bins and classifies the spectrum as a filter response.
// ----------------------------------------------------------------------------
// Bins enter on bin_i one transaction per cycle, from bin 0, with final_bin
// marking the last one. Each bin is compared against level_threshold
// (above means magnitude >= threshold) and edges at bin i are judged from
// bins i-1 and i+1. On the final bin one result transaction leaves on
// result_o: kind, first rise index and reported fall index. Throughput is one
// bin per cycle unless a final bin stalls; result_o.valid is set when the
// final bin moves from the input register into the result register. The
// only stall comes from the result register: while it holds an unconsumed
// result, a further final bin waits in the input register. bin_i.ready
// follows result_o.ready within the same cycle. No clearing pass is needed
// after reset. The threshold write channel is always ready and should be
// used only while no spectrum is in flight.
// ----------------------------------------------------------------------------
module spectrum_passband_classifier_core
  import spc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  spc_cfg_if.sink      cfg_i,
  spc_bin_if.sink      bin_i,
  spc_result_if.source result_o
);

  // Threshold register
  logic [THR_W-1:0] thr_q;

  // Input register
  logic             in_vld_q;
  logic [MAG_W-1:0] in_mag_q;
  logic             in_fin_q;

  // Result register
  logic         out_vld_q;
  spc_result_t  out_q;

  logic         out_free;
  logic         step;
  spc_summary_t summary;
  spc_result_t  result;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_i.valid) begin
      thr_q <= cfg_i.level_threshold;
    end
  end

  // A non-final bin retires freely; a final bin needs room in the result reg.
  assign out_free    = !out_vld_q || result_o.ready;
  assign step        = in_vld_q && (!in_fin_q || out_free);
  assign bin_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (bin_i.ready) begin
      in_vld_q <= bin_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bin_i.valid && bin_i.ready) begin
      in_mag_q <= bin_i.magnitude;
      in_fin_q <= bin_i.final_bin;
    end
  end

  spc_edge_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .mag_i     (in_mag_q),
    .final_i   (in_fin_q),
    .thr_i     (thr_q),
    .summary_o (summary)
  );

  spc_classifier u_classifier (
    .summary_i (summary),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step && in_fin_q) begin
      out_vld_q <= 1'b1;
    end else if (result_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && in_fin_q) begin
      out_q <= result;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.filter_kind = out_q.kind;
  assign result_o.rise_bin    = out_q.rise_bin;
  assign result_o.fall_bin    = out_q.fall_bin;

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for spectrum_passband_classifier_core. Spectra are
// streamed bin by bin under several thresholds and idling mixes. A local edge
// tracker predicts each classification, and results are checked in order.
// ----------------------------------------------------------------------------
module tb;
  import spc_pkg::*;

  // Quiet cycles (no transaction on any channel) before the run is called hung
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Extra margin once all results are back
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst_n;

  spc_cfg_if    cfg_if ();
  spc_bin_if    bin_if ();
  spc_result_if res_if ();

  spectrum_passband_classifier_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_if),
    .bin_i   (bin_if),
    .result_o(res_if)
  );

  // --------------------------------------------------------------------------
  // Edge tracker shadow: threshold plus the per-spectrum state
  // --------------------------------------------------------------------------
  logic [THR_W-1:0] level_thr;
  int unsigned      bin_idx;      // saturates at MAX_BINS
  logic [1:0]       hi_hist;      // bit 0 = newest bin
  logic             all_hi;
  logic             rise_seen, fall_seen, far_seen;
  int unsigned      rise_at, fall_at, far_at;

  spc_result_t      pending_results[$];

  int unsigned      gap_pct;      // chance per cycle that the bin side idles
  int unsigned      stall_pct;    // chance per cycle that result ready is low
  int unsigned      bins_sent;
  int unsigned      errors;

  function automatic void clear_spectrum();
    bin_idx   = 0;
    hi_hist   = 2'b00;
    all_hi    = 1'b1;
    rise_seen = 1'b0;
    fall_seen = 1'b0;
    far_seen  = 1'b0;
    rise_at   = 0;
    fall_at   = 0;
    far_at    = 0;
  endfunction

  // Advance the shadow by one bin; a final bin queues the expected result.
  function automatic void classify_bin(input logic [MAG_W-1:0] mag, input logic fin);
    logic        hi;
    logic        was_hi;
    int unsigned e;
    spc_result_t r;
    hi = ((mag & SAMPLE_MASK) >= level_thr);
    if (!hi) all_hi = 1'b0;
    // Edge at e = idx-1 is judged from bins e-1 and e+1; edges at MAX_BINS-1
    // and beyond are dropped, but bins still count toward fullpass.
    if (bin_idx >= 2 && bin_idx < MAX_BINS) begin
      e      = bin_idx - 1;
      was_hi = hi_hist[1];
      if (!was_hi && hi) begin
        // only the first rise is kept
        if (!rise_seen) begin
          rise_seen = 1'b1;
          rise_at   = e;
        end
      end else if (was_hi && !hi) begin
        if (!fall_seen) begin
          fall_seen = 1'b1;
          fall_at   = e;
        end
        if (rise_seen && !far_seen && e >= rise_at + 2) begin
          far_seen = 1'b1;
          far_at   = e;
        end
      end
    end
    hi_hist = {hi_hist[0], hi};
    if (bin_idx < MAX_BINS) bin_idx++;
    if (fin) begin
      r.kind     = KIND_NONE;
      r.rise_bin = '0;
      r.fall_bin = '0;
      if (all_hi) begin
        r.kind = KIND_FULLPASS;
      end else if (rise_seen) begin
        r.rise_bin = OUT_IDX_W'(rise_at);
        if (far_seen) begin
          r.kind     = KIND_BANDPASS;
          r.fall_bin = OUT_IDX_W'(far_at);
        end else if (fall_seen) begin
          r.kind     = KIND_BANDSTOP;
          r.fall_bin = OUT_IDX_W'(fall_at);
        end else begin
          r.kind = KIND_HIGHPASS;
        end
      end else if (fall_seen) begin
        r.kind     = KIND_LOWPASS;
        r.fall_bin = OUT_IDX_W'(fall_at);
      end
      pending_results.push_back(r);
      clear_spectrum();
    end
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // --------------------------------------------------------------------------
  // Clock, reset, result-side backpressure
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: every result transaction against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    spc_result_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result kind=%0d rise=%0d fall=%0d",
                             res_if.filter_kind, res_if.rise_bin, res_if.fall_bin));
      end else begin
        want = pending_results.pop_front();
        if (res_if.filter_kind !== want.kind)
          flag_error($sformatf("filter_kind exp %0d got %0d", want.kind,
                               res_if.filter_kind));
        if (res_if.rise_bin !== want.rise_bin)
          flag_error($sformatf("rise_bin exp %0d got %0d", want.rise_bin,
                               res_if.rise_bin));
        if (res_if.fall_bin !== want.fall_bin)
          flag_error($sformatf("fall_bin exp %0d got %0d", want.fall_bin,
                               res_if.fall_bin));
      end
    end
  end

  // Hang detection: counts cycles with no transaction on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("[spectrum_passband_classifier_core] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // One bin transaction, with random idle cycles ahead of it
  task automatic send_bin(input logic [MAG_W-1:0] mag, input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      bin_if.valid <= 1'b0;
      @(negedge clk);
    end
    bin_if.valid     <= 1'b1;
    bin_if.magnitude <= mag;
    bin_if.final_bin <= fin;
    forever begin
      @(posedge clk);
      if (bin_if.ready) break;
    end
    classify_bin(mag, fin);
    bins_sent++;
  endtask

  // Pattern letters, relative to the current threshold:
  //   H all ones, Z zero, A exactly at threshold, B one below it,
  //   a random at/above, b random below (thr 0 has nothing below, gives 0).
  function automatic logic [MAG_W-1:0] level_for(input byte c);
    case (c)
      "H":     return '1;
      "Z":     return '0;
      "A":     return level_thr;
      "B":     return level_thr - 1;
      "b":     return (level_thr == 0) ? '0 : MAG_W'($urandom_range(level_thr - 1, 0));
      default: return MAG_W'($urandom_range(32'hFFFF_FFFF, level_thr));
    endcase
  endfunction

  // Sends one whole spectrum; the last letter carries final_bin.
  task automatic send_spectrum(input string pattern);
    int n;
    n = pattern.len();
    for (int i = 0; i < n; i++) send_bin(level_for(pattern[i]), (i == n - 1));
  endtask

  // Bin side idle, then wait until all results are back plus the pipeline
  task automatic settle();
    @(negedge clk);
    bin_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    settle();
    @(negedge clk);
    cfg_if.valid           <= 1'b1;
    cfg_if.level_threshold <= value;
    forever begin
      @(posedge clk);
      if (cfg_if.ready) break;
    end
    level_thr = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random above/below shape. Mostly runs of equal level (real passbands),
  // some per-bin noise, some flat spectra. Boundary values show up now and then.
  function automatic string random_shape(input int unsigned len, input int unsigned max_run);
    string       s;
    string       letter;
    int unsigned mode;
    int unsigned run;
    bit          hi;
    mode = $urandom_range(3);
    hi   = $urandom_range(1);
    run  = $urandom_range(max_run, 1);
    s    = "";
    for (int unsigned i = 0; i < len; i++) begin
      case (mode)
        0, 1: begin
          if (run == 0) begin
            hi  = !hi;
            run = $urandom_range(max_run, 1);
          end
          run--;
        end
        2: hi = $urandom_range(1);
        default: ;  // flat
      endcase
      if ($urandom_range(7) == 0) begin
        if (hi) letter = $urandom_range(1) ? "A" : "H";
        else    letter = $urandom_range(1) ? "B" : "Z";
      end else begin
        letter = hi ? "a" : "b";
      end
      s = {s, letter};
    end
    return s;
  endfunction

  task automatic run_random_spectra(input int unsigned n_bins);
    int unsigned target;
    int unsigned len;
    target = bins_sent + n_bins;
    while (bins_sent < target) begin
      len = ($urandom_range(9) != 0) ? $urandom_range(24, 1) : $urandom_range(96, 25);
      send_spectrum(random_shape(len, 6));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Threshold is 0 out of reset, so anything counts as above
  task automatic test_reset_threshold();
    send_spectrum("ZZ");
    write_threshold('0);
    send_spectrum("Z");
  endtask

  // Fewer than three bins: no edge can exist
  task automatic test_short_spectra();
    write_threshold(32'h8000_0000);
    send_spectrum("H");
    send_spectrum("Z");
    send_spectrum("ZH");
    send_spectrum("HZ");
  endtask

  task automatic test_filter_kinds();
    write_threshold(32'd100);
    send_spectrum("HABZ");     // lowpass, fall at 1
    send_spectrum("ZBa");      // highpass, rise at 1
    send_spectrum("ZaaB");     // fall right after rise: bandstop 1/2
    send_spectrum("aBbA");     // fall before rise: bandstop 2/1
    // rises at 1 and 2, fall at 3: far enough only from the first rise,
    // so bandpass shows the later rise was ignored
    send_spectrum("ZbHAbab");
  endtask

  task automatic test_random_streaming();
    write_threshold($urandom);
    gap_pct   = 0;
    stall_pct = 0;
    run_random_spectra(140);
  endtask

  task automatic test_sender_gaps();
    write_threshold(32'hFFFF_FFFF);
    gap_pct   = 74;
    stall_pct = 0;
    run_random_spectra(140);
  endtask

  task automatic test_receiver_stalls();
    write_threshold($urandom);
    gap_pct   = 0;
    stall_pct = 74;
    run_random_spectra(140);
  endtask

  task automatic test_mixed_idling();
    write_threshold(32'd1);
    gap_pct   = 17;
    stall_pct = 17;
    run_random_spectra(140);
  endtask

  // Longer than MAX_BINS with a busy tail, so edges land on both sides of
  // the last legal edge index
  task automatic test_overlong_spectrum();
    int unsigned head;
    write_threshold($urandom);
    gap_pct   = 17;
    stall_pct = 17;
    head = MAX_BINS - $urandom_range(14, 4);
    send_spectrum({random_shape(head, 40), random_shape($urandom_range(40, 16), 2)});
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                  = 1'b0;
    bin_if.valid           = 1'b0;
    bin_if.magnitude       = '0;
    bin_if.final_bin       = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.level_threshold = '0;
    level_thr              = '0;
    gap_pct                = 0;
    stall_pct              = 0;
    bins_sent              = 0;
    errors                 = 0;
    clear_spectrum();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    test_reset_threshold();
    test_short_spectra();
    test_filter_kinds();
    test_random_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_overlong_spectrum();
    settle();

    if (errors == 0) begin
      $display("[spectrum_passband_classifier_core] OK");
    end else begin
      $display("[spectrum_passband_classifier_core] ERROR");
    end
    $finish;
  end

endmodule
